/* rtl/msps_pkg.sv */
// shared types and constants of the masked stride pattern search unit
package msps_pkg;

   // one result item as it waits in the result queue
   typedef struct packed {
      logic        kind;
      logic [31:0] value;
      logic [31:0] offset;
      logic [15:0] total;
      logic        not_found;
      logic        last;
   } rsp_item_type;

   // result kinds carried on tuser
   localparam logic KIND_MATCH   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_MASK        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIDE           = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIND_TARGET      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALUE_BIAS       = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATALOAD_SELECT  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLACKLIST_BOUNDS = 3'd7;

   // result queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   // result tdata: value, offset, total, not_found, padded to whole bytes
   localparam int RSP_TDATA_W = 88;

endpackage

/* rtl/msps_rsp_queue.sv */
// small result queue taking up to two results per cycle and giving one
module msps_rsp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 push_count,
   input  msps_pkg::rsp_item_type     push_item0,
   input  msps_pkg::rsp_item_type     push_item1,
   input  logic                       pop,
   output msps_pkg::rsp_item_type     head,
   output logic                       head_valid,
   output logic [msps_pkg::RSP_CNT_W-1:0] fill
);
   import msps_pkg::*;

   rsp_item_type               entries_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]       count_ff, count_in;
   logic [RSP_PTR_W-1:0]       wr_ptr_next;

   always_comb begin
      wr_ptr_next = wr_ptr_ff + RSP_PTR_W'(1);
      wr_ptr_in   = wr_ptr_ff + RSP_PTR_W'(push_count);
      rd_ptr_in   = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in    = count_ff + RSP_CNT_W'(push_count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_item0;
      end
      if (push_count == 2'd2) begin
         entries_ff[wr_ptr_next] <= push_item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head       = entries_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign fill       = count_ff;

endmodule

/* rtl/masked_stride_pattern_search_unit.sv */
// top level of the masked stride pattern search unit
// a request byte is registered in the input stage and examined there once the result queue
//   has room for two results; its results are written to the result queue, whose head drives rsp
// throughput: one byte per cycle while the result queue has room for two results; the queue
//   drains one result per cycle, so a byte that gives both a match and a summary can hold intake
// reset: synchronous, active high; clears the search state, queue and input stage and
//   loads the register defaults; the byte window is not cleared (never read before filled)
module masked_stride_pattern_search_unit #(
   parameter int PATTERN_BYTES = 8,
   parameter int WINDOW_BYTES  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // [7:0] data_byte
   input  logic                                req_tlast,  // end_of_binary
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] match_value, [63:32] match_offset, [79:64] match_total, [80] not_found
   output logic [msps_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tuser,  // result_kind
   output logic                                rsp_tlast,  // last_result
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [msps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]                         csr_data
);
   import msps_pkg::*;

   localparam int SPAN_W = $clog2(WINDOW_BYTES + 1);

   // configuration registers
   logic [63:0] pattern_bytes_ff;
   logic [63:0] byte_mask_ff;
   logic [3:0]  pattern_len_ff;
   logic [15:0] stride_ff;
   logic [15:0] find_target_ff;
   logic [31:0] value_bias_ff;
   logic [3:0]  dataload_select_ff;
   logic [63:0] blacklist_bounds_ff;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   // per-binary search state
   logic [WINDOW_BYTES-1:0][7:0] window_ff, window_in;
   logic [31:0] bytes_seen_ff, bytes_seen_in;
   logic [15:0] stride_phase_ff, stride_phase_in;
   logic [15:0] accepted_count_ff, accepted_count_in;
   logic        search_stopped_ff, search_stopped_in;

   // datapath
   logic              process;
   logic              req_accept;
   logic              csr_write;
   logic              load_mode;
   logic [SPAN_W-1:0] plen, loff, span, span_m1, span_raw;
   logic              examine, candidate, hit, blacklisted, accept_match;
   logic [16:0]       phase_next;
   logic [15:0]       phase_step;
   logic [31:0]       pos, load_word, value;
   logic [15:0]       count_inc, count_after;
   logic              stop_set;
   logic [7:0]        win_byte;

   // result queue
   rsp_item_type               match_item, summary_item, push_item0, push_item1, head;
   logic [1:0]                 push_count;
   logic                       head_valid, pop;
   logic [RSP_CNT_W-1:0]       q_fill;

   // picks window tap idx; an index past the window reads as zero
   function automatic logic [7:0] tap(input logic [WINDOW_BYTES-1:0][7:0] win,
                                      input logic [SPAN_W-1:0] idx);
      logic [7:0] sel;
      sel = 8'h00;
      for (int t = 0; t < WINDOW_BYTES; t++) begin
         if (idx == SPAN_W'(t)) begin
            sel = win[t];
         end
      end
      return sel;
   endfunction

   // ---------------- configuration port ----------------
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff    <= '0;
         byte_mask_ff        <= '1;
         pattern_len_ff      <= 4'd4;
         stride_ff           <= 16'd4;
         find_target_ff      <= 16'd1;
         value_bias_ff       <= '0;
         dataload_select_ff  <= '0;
         blacklist_bounds_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:    pattern_bytes_ff    <= csr_data;
            CSR_BYTE_MASK:        byte_mask_ff        <= csr_data;
            CSR_PATTERN_LEN:      pattern_len_ff      <= csr_data[3:0];
            CSR_STRIDE:           stride_ff           <= csr_data[15:0];
            CSR_FIND_TARGET:      find_target_ff      <= csr_data[15:0];
            CSR_VALUE_BIAS:       value_bias_ff       <= csr_data[31:0];
            CSR_DATALOAD_SELECT:  dataload_select_ff  <= csr_data[3:0];
            CSR_BLACKLIST_BOUNDS: blacklist_bounds_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- input stage ----------------
   // the stage is processed once the queue has room for two results
   assign process    = in_valid_ff && (q_fill <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign req_tready = !in_valid_ff || process;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata[7:0];
         in_last_ff <= req_tlast;
      end
   end

   // ---------------- span and candidate ----------------
   always_comb begin
      // effective pattern length, saturated to the pattern width
      if (SPAN_W'(pattern_len_ff) > SPAN_W'(PATTERN_BYTES)) begin
         plen = SPAN_W'(PATTERN_BYTES);
      end else begin
         plen = SPAN_W'(pattern_len_ff);
      end

      // load distance, saturated so the word stays inside the window
      load_mode = (dataload_select_ff != 4'd0);
      loff      = SPAN_W'(dataload_select_ff - 4'd1);
      if (!load_mode) begin
         loff = '0;
      end else if (loff > SPAN_W'(WINDOW_BYTES - 4)) begin
         loff = SPAN_W'(WINDOW_BYTES - 4);
      end

      // bytes a candidate needs before it can be examined
      span_raw = plen;
      if (load_mode && (loff + SPAN_W'(4) > plen)) begin
         span_raw = loff + SPAN_W'(4);
      end
      span    = (span_raw == '0) ? SPAN_W'(1) : span_raw;
      span_m1 = span - SPAN_W'(1);

      window_in = {window_ff[WINDOW_BYTES-2:0], in_byte_ff};

      examine   = (bytes_seen_ff >= 32'(span_m1));
      candidate = examine && (stride_phase_ff == 16'd0) && !search_stopped_ff;

      // stride zero behaves as stride one; a stale phase wraps at the next step
      phase_next = {1'b0, stride_phase_ff} + 17'd1;
      phase_step = (phase_next >= {1'b0, stride_ff}) ? 16'd0 : phase_next[15:0];

      pos = bytes_seen_ff - 32'(span_m1);
   end

   // ---------------- masked compare, load and value ----------------
   always_comb begin
      hit = 1'b1;
      for (int j = 0; j < PATTERN_BYTES; j++) begin
         win_byte = tap(window_in, span_m1 - SPAN_W'(j));
         if ((SPAN_W'(j) < plen) &&
             ((win_byte & byte_mask_ff[8*j +: 8]) != pattern_bytes_ff[8*j +: 8])) begin
            hit = 1'b0;
         end
      end
      win_byte = 8'h00;

      // little-endian word at the load distance from the match start
      for (int j = 0; j < 4; j++) begin
         load_word[8*j +: 8] = tap(window_in, span_m1 - loff - SPAN_W'(j));
      end

      value = (load_mode ? load_word : pos) + value_bias_ff;

      blacklisted  = (value >= blacklist_bounds_ff[31:0]) &&
                     (value <  blacklist_bounds_ff[63:32]);
      accept_match = candidate && hit && !blacklisted;

      count_inc   = (accepted_count_ff == 16'hFFFF) ? accepted_count_ff
                                                    : accepted_count_ff + 16'd1;
      count_after = accept_match ? count_inc : accepted_count_ff;
      stop_set    = accept_match && (find_target_ff != 16'd0) &&
                    (count_inc == find_target_ff);
   end

   // ---------------- state update ----------------
   always_comb begin
      if (in_last_ff) begin
         // end of binary: per-binary state starts over
         bytes_seen_in     = '0;
         stride_phase_in   = '0;
         accepted_count_in = '0;
         search_stopped_in = 1'b0;
      end else begin
         bytes_seen_in     = bytes_seen_ff + 32'd1;
         stride_phase_in   = examine ? phase_step : stride_phase_ff;
         accepted_count_in = count_after;
         search_stopped_in = search_stopped_ff || stop_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff     <= '0;
         stride_phase_ff   <= '0;
         accepted_count_ff <= '0;
         search_stopped_ff <= 1'b0;
      end else if (process) begin
         bytes_seen_ff     <= bytes_seen_in;
         stride_phase_ff   <= stride_phase_in;
         accepted_count_ff <= accepted_count_in;
         search_stopped_ff <= search_stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         window_ff <= window_in;
      end
   end

   // ---------------- results ----------------
   always_comb begin
      match_item.kind      = KIND_MATCH;
      match_item.value     = value;
      match_item.offset    = pos;
      match_item.total     = count_after;
      match_item.not_found = 1'b0;
      match_item.last      = !in_last_ff;

      summary_item.kind      = KIND_SUMMARY;
      summary_item.value     = '0;
      summary_item.offset    = '0;
      summary_item.total     = count_after;
      summary_item.not_found = (count_after == 16'd0);
      summary_item.last      = 1'b1;

      // a match goes first; a summary alone takes the first slot
      push_item0 = accept_match ? match_item : summary_item;
      push_item1 = summary_item;
      push_count = process ? (2'(accept_match) + 2'(in_last_ff)) : 2'd0;
   end

   assign pop = rsp_tvalid && rsp_tready;

   msps_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_item0 (push_item0),
      .push_item1 (push_item1),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .fill       (q_fill)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {7'b0, head.not_found, head.total, head.offset, head.value};

   // ---------------- assertions ----------------
   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_fill <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overfilled");

   // a stopped search reports no further match
   a_stopped_quiet: assert property (@(posedge clock) disable iff (reset)
      search_stopped_ff |-> !accept_match)
      else $error("match reported after search stopped");

   // a summary is always the final result of its request
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_SUMMARY)) |-> rsp_tlast)
      else $error("summary not marked last");

   // end of binary leaves clean per-binary state
   a_clear_on_end: assert property (@(posedge clock) disable iff (reset)
      (process && in_last_ff) |=>
         (bytes_seen_ff == 32'd0) && (accepted_count_ff == 16'd0) && !search_stopped_ff)
      else $error("per-binary state not cleared at end of binary");

endmodule
